### sv/mandelbrot_escape_time_macros.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape time: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication.
`define MBE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MBE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time: package
// Shared constants and types for the front end, queue and iteration engine.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// Iteration count and limit register width.
	localparam int ITER_W = 10;
	localparam logic [ITER_W-1:0] MAX_ITER_RESET = 10'd100;

	// Default coordinate format, Q4.28.
	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_FRAC_BITS = 28;

	// Depth of the queue between front end and engine.
	localparam int DEF_QUEUE_DEPTH = 2;

	// Digit width of the shared partial-product multipliers.
	localparam int MUL_DIG_W = 32;

	// Per-point tag that travels with the coordinates.
	typedef struct packed {
		logic [ITER_W-1:0] max_iter;
		logic              trivial;
	} mbe_tag_t;

	localparam int TAG_W = $bits(mbe_tag_t);

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} mbe_qstat_t;

endpackage

### sv/mbe_point_if.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time: point channel
// Carries one complex point c per beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbe_point_if import mbe_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] c_real;
	logic signed [COORD_WIDTH-1:0] c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

### sv/mbe_result_if.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time: result channel
// Carries the iteration count and the in-set flag per beat.
// ----------------------------------------------------------------------------
interface mbe_result_if import mbe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ITER_W-1:0] iteration_count;
	logic              in_set;

	modport source (output valid, output iteration_count, output in_set, input ready);
	modport sink (input valid, input iteration_count, input in_set, output ready);
endinterface

### sv/mbe_cfg_if.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time: configuration channel
// Write channel for the iteration limit register.
// ----------------------------------------------------------------------------
interface mbe_cfg_if import mbe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ITER_W-1:0] max_iterations;

	modport source (output valid, output max_iterations, input ready);
	modport sink (input valid, input max_iterations, output ready);
endinterface

### sv/mandelbrot_escape_time.sv
// The engine holds one point at a time and takes the next from the queue only when idle.
// ND = ceil(width/32) digits per coordinate, so ND is one in Q4.28.
// A round runs the shared digit multipliers, a drain step, the escape test and the update step.
// Reset clears the queue and the engine and sets max_iterations back to 100.
// ----------------------------------------------------------------------------
// Mandelbrot escape time: top level
// Front end, point queue and iteration engine for escape-time counts.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbe_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = DEF_FRAC_BITS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	mbe_point_if.sink    point,
	mbe_cfg_if.sink      cfg,
	mbe_result_if.source result
);
	localparam int EW = TAG_W + 2 * COORD_WIDTH;

	mbe_qstat_t    qstat;
	logic          push;
	logic          pop;
	logic [EW-1:0] wdata;
	logic [EW-1:0] rdata;

	// Front end: limit register and point acceptance.
	mbe_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (point),
		.cfg    (cfg),
		.qstat  (qstat),
		.push   (push),
		.wdata  (wdata)
	);

	// Queue between front end and engine.
	mbe_queue #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.stat   (qstat)
	);

	// Iteration engine with result register.
	mbe_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.pop    (pop),
		.qdata  (rdata),
		.result (result)
	);

endmodule

### sv/mbe_queue.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time: point queue
// Small register FIFO that decouples the front end from the engine.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_macros.svh"

module mbe_queue import mbe_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output mbe_qstat_t       stat
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// Status and head of the queue.
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = entry_q[rd_ptr_q];

	// Entry storage, no reset needed.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`MBE_ASSERT_IMP(a_no_pop_empty, pop, !stat.empty, "queue popped while empty")
	`MBE_ASSERT_IMP(a_no_push_full, push && !pop, !stat.full, "queue pushed while full")

endmodule

### sv/mbe_front.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time: front end
// Holds the iteration limit, accepts points and tags them for the engine.
// ----------------------------------------------------------------------------
module mbe_front import mbe_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mbe_point_if.sink                          point,
	mbe_cfg_if.sink                            cfg,
	input  mbe_qstat_t                         qstat,
	output logic                               push,
	output logic [TAG_W+2*COORD_WIDTH-1:0]     wdata
);
	logic [ITER_W-1:0] max_iter_q;
	mbe_tag_t          tag;

	// Iteration limit register, always writable.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RESET;
		end else if (cfg.valid) begin
			max_iter_q <= cfg.max_iterations;
		end
	end

	// Points with a zero limit need no rounds at all.
	assign tag.max_iter = max_iter_q;
	assign tag.trivial  = (max_iter_q == '0);

	// Accept a beat whenever the queue has room.
	assign point.ready = !qstat.full;
	assign push        = point.valid && !qstat.full;
	assign wdata       = {tag, point.c_imag, point.c_real};

endmodule

### sv/mbe_back.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time: iteration engine
// Runs z = z^2 + c rounds with shared digit multipliers and holds the result.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_macros.svh"

module mbe_back import mbe_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mbe_qstat_t                         qstat,
	output logic                               pop,
	input  logic [TAG_W+2*COORD_WIDTH-1:0]     qdata,
	mbe_result_if.source                       result
);
	localparam int W       = COORD_WIDTH;
	localparam int F       = FRAC_BITS;
	localparam int DG      = MUL_DIG_W;
	localparam int ND      = (W + DG - 1) / DG;
	localparam int XW      = ND * DG;
	localparam int AW      = 2 * W;
	localparam int AXW     = 2 * XW;
	localparam int PW      = 2 * DG;
	localparam int IW      = (ND > 1) ? $clog2(ND) : 1;
	localparam int SHW     = (ND > 1) ? $clog2(2 * ND) : 1;
	localparam int ESC_LSB = 2 * F + 2;
	localparam int SW      = (AW + 1 > ESC_LSB + 1) ? AW + 1 : ESC_LSB + 1;
	localparam int SATW    = AW + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_TEST  = 3'd3;
	localparam logic [2:0] ST_UPD   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]             state_q;
	logic signed [W-1:0]    cr_q;
	logic signed [W-1:0]    ci_q;
	logic signed [W-1:0]    zr_q;
	logic signed [W-1:0]    zi_q;
	logic [ITER_W-1:0]      max_q;
	logic [ITER_W-1:0]      round_q;
	logic [IW-1:0]          i_q;
	logic [IW-1:0]          j_q;
	logic [PW-1:0]          pp_rr_s1;
	logic [PW-1:0]          pp_ii_s1;
	logic [PW-1:0]          pp_ri_s1;
	logic [SHW-1:0]         sh_s1;
	logic                   ppv_s1;
	logic [AW-1:0]          acc_rr_q;
	logic [AW-1:0]          acc_ii_q;
	logic [AW-1:0]          acc_ri_q;
	logic signed [AW-1:0]   diff_q;
	logic signed [AW-1:0]   prod_q;
	logic [ITER_W-1:0]      fin_cnt_q;
	logic                   fin_inset_q;
	logic                   res_valid_q;
	logic [ITER_W-1:0]      res_cnt_q;
	logic                   res_inset_q;

	mbe_tag_t               ld_tag;
	logic signed [W-1:0]    ld_cr;
	logic signed [W-1:0]    ld_ci;
	logic [W-1:0]           mag_r;
	logic [W-1:0]           mag_i;
	logic [XW-1:0]          mag_r_x;
	logic [XW-1:0]          mag_i_x;
	logic [DG-1:0]          dig_ri;
	logic [DG-1:0]          dig_rj;
	logic [DG-1:0]          dig_ij;
	logic [AXW-1:0]         sh_rr;
	logic [AXW-1:0]         sh_ii;
	logic [AXW-1:0]         sh_ri;
	logic [AW:0]            mag_sum;
	logic [SW-1:0]          mag_sum_x;
	logic                   escape;
	logic signed [AW-1:0]   re_sh;
	logic signed [AW-1:0]   im_sh;
	logic signed [SATW-1:0] nr;
	logic signed [SATW-1:0] ni;
	logic signed [W-1:0]    zr_n;
	logic signed [W-1:0]    zi_n;
	logic [ITER_W-1:0]      round_n;
	logic                   out_free;
	logic                   last_step;

	// Queue head unpack.
	assign {ld_tag, ld_ci, ld_cr} = qdata;
	assign pop = (state_q == ST_IDLE) && !qstat.empty;

	// Magnitudes of z and the digits selected for this step.
	assign mag_r   = zr_q[W-1] ? (~zr_q + 1'b1) : zr_q;
	assign mag_i   = zi_q[W-1] ? (~zi_q + 1'b1) : zi_q;
	assign mag_r_x = XW'(mag_r);
	assign mag_i_x = XW'(mag_i);
	assign dig_ri  = mag_r_x[i_q*DG +: DG];
	assign dig_rj  = mag_r_x[j_q*DG +: DG];
	assign dig_ij  = mag_i_x[j_q*DG +: DG];
	assign last_step = (i_q == IW'(ND - 1)) && (j_q == IW'(ND - 1));

	// Registered partial products are shifted into place for accumulation.
	assign sh_rr = AXW'(pp_rr_s1) << (sh_s1 * DG);
	assign sh_ii = AXW'(pp_ii_s1) << (sh_s1 * DG);
	assign sh_ri = AXW'(pp_ri_s1) << (sh_s1 * DG);

	// Escape test: |z|^2 at or above four at product scale.
	assign mag_sum   = {1'b0, acc_rr_q} + {1'b0, acc_ii_q};
	assign mag_sum_x = SW'(mag_sum);
	assign escape    = |mag_sum_x[SW-1:ESC_LSB];

	// Update: rescale, add c, saturate to the coordinate range.
	assign re_sh = diff_q >>> F;
	assign im_sh = prod_q >>> (F - 1);
	assign nr    = SATW'(re_sh) + SATW'(cr_q);
	assign ni    = SATW'(im_sh) + SATW'(ci_q);

	always_comb begin
		if (nr[SATW-1:W-1] != {(SATW-W+1){nr[SATW-1]}}) begin
			zr_n = {nr[SATW-1], {(W-1){~nr[SATW-1]}}};
		end else begin
			zr_n = nr[W-1:0];
		end
		if (ni[SATW-1:W-1] != {(SATW-W+1){ni[SATW-1]}}) begin
			zi_n = {ni[SATW-1], {(W-1){~ni[SATW-1]}}};
		end else begin
			zi_n = ni[W-1:0];
		end
	end

	assign round_n  = round_q + 1'b1;
	assign out_free = !res_valid_q || result.ready;

	// Digit multipliers, one step per cycle.
	always_ff @(posedge clk) begin
		pp_rr_s1 <= PW'(dig_ri) * PW'(dig_rj);
		pp_ii_s1 <= PW'(mag_i_x[i_q*DG +: DG]) * PW'(dig_ij);
		pp_ri_s1 <= PW'(dig_ri) * PW'(dig_ij);
		sh_s1    <= SHW'(i_q) + SHW'(j_q);
	end

	// Point and datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					cr_q     <= ld_cr;
					ci_q     <= ld_ci;
					zr_q     <= '0;
					zi_q     <= '0;
					acc_rr_q <= '0;
					acc_ii_q <= '0;
					acc_ri_q <= '0;
				end
			end
			ST_MUL, ST_DRAIN: begin
				if (ppv_s1) begin
					acc_rr_q <= acc_rr_q + AW'(sh_rr);
					acc_ii_q <= acc_ii_q + AW'(sh_ii);
					acc_ri_q <= acc_ri_q + AW'(sh_ri);
				end
			end
			ST_TEST: begin
				diff_q <= acc_rr_q - acc_ii_q;
				prod_q <= (zr_q[W-1] ^ zi_q[W-1]) ? (~acc_ri_q + 1'b1) : acc_ri_q;
			end
			ST_UPD: begin
				zr_q     <= zr_n;
				zi_q     <= zi_n;
				acc_rr_q <= '0;
				acc_ii_q <= '0;
				acc_ri_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// Round sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_q       <= '0;
			round_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			ppv_s1      <= 1'b0;
			fin_cnt_q   <= '0;
			fin_inset_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_cnt_q   <= '0;
			res_inset_q <= 1'b0;
		end else begin
			ppv_s1 <= (state_q == ST_MUL);
			// The result register fills from the final state and empties once its beat is taken.
			if ((state_q == ST_FIN) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						max_q   <= ld_tag.max_iter;
						round_q <= '0;
						i_q     <= '0;
						j_q     <= '0;
						if (ld_tag.trivial) begin
							fin_cnt_q   <= '0;
							fin_inset_q <= 1'b1;
							state_q     <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (j_q == IW'(ND - 1)) begin
						j_q <= '0;
						i_q <= (i_q == IW'(ND - 1)) ? '0 : i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
					if (last_step) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (escape) begin
						fin_cnt_q   <= round_q;
						fin_inset_q <= 1'b0;
						state_q     <= ST_FIN;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					round_q <= round_n;
					if (round_n == max_q) begin
						fin_cnt_q   <= round_n;
						fin_inset_q <= 1'b1;
						state_q     <= ST_FIN;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_cnt_q   <= fin_cnt_q;
						res_inset_q <= fin_inset_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid           = res_valid_q;
	assign result.iteration_count = res_cnt_q;
	assign result.in_set          = res_inset_q;

	`MBE_ASSERT_IMP(a_round_bound, state_q != ST_IDLE, round_q <= max_q, "round count passed limit")
	`MBE_ASSERT_IMP(a_steps_wrapped, state_q == ST_TEST, (i_q == '0) && (j_q == '0), "digit steps not wrapped")
	`MBE_ASSERT_IMP(a_escape_early, (state_q == ST_FIN) && !fin_inset_q, fin_cnt_q < max_q, "escape count at or past limit")
	`MBE_ASSERT_NXT(a_inset_count, (state_q == ST_FIN) && out_free && fin_inset_q, res_cnt_q == $past(max_q), "in-set count differs from limit")

endmodule
